/* hw/rtl/lsfb_pkg.sv */
// Shared constants, command codes and types for the LED strip frame buffer.
`default_nettype none

package lsfb_pkg;

    localparam int MAX_LEDS = 64;
    localparam int IDX_W    = $clog2(MAX_LEDS);
    localparam int CNT_W    = $clog2(MAX_LEDS + 1);

    localparam int CMD_W      = 3;
    localparam int PIX_IDX_W  = 7;
    localparam int CHAN_W     = 8;
    localparam int COLOUR_W   = 3 * CHAN_W;
    localparam int LEDCOUNT_W = 7;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Rainbow hue spacing: 256 / count, worked out serially
    localparam int HUE_SPAN   = 256;
    localparam int HUE_DIV_W  = 9;
    localparam int HUE_REGION = 43;

    localparam logic [CMD_W-1:0] CMD_SET_PIXEL = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FILL      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CHASE     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RAINBOW   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SHOW      = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 2'd2;

    // Flags travelling with a pixel through the show pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } beat_t;

endpackage

`default_nettype wire

/* hw/rtl/lsfb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lsfb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hw/rtl/lsfb_div.sv */
// Restoring divider giving 256 / count and its remainder, one bit a cycle.
`default_nettype none

module lsfb_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [lsfb_pkg::CNT_W-1:0]  divisor,
    output      logic                        done,
    output      logic [lsfb_pkg::HUE_DIV_W-1:0] quot,
    output      logic [lsfb_pkg::CNT_W-1:0]  rem
);

    import lsfb_pkg::*;

    localparam int STEP_W = $clog2(HUE_DIV_W + 1);

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [STEP_W-1:0]    step_reg,  step_next;
    logic [HUE_DIV_W-1:0] quo_reg,   quo_next;
    logic [CNT_W-1:0]     rem_reg,   rem_next;
    logic [CNT_W:0]       trial;
    logic [CNT_W:0]       diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[HUE_DIV_W-1]};
        diff      = trial - {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(HUE_DIV_W);
            quo_next  = HUE_DIV_W'(HUE_SPAN);
            rem_next  = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = diff[CNT_W-1:0];
                quo_next = {quo_reg[HUE_DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[HUE_DIV_W-2:0], 1'b0};
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

/* hw/rtl/lsfb_scale.sv */
// Brightness scaling pipeline and output register for the show stream.
`default_nettype none

module lsfb_scale (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [lsfb_pkg::CHAN_W-1:0]    brightness,
    input  wire lsfb_pkg::beat_t                in_beat,
    input  wire logic [lsfb_pkg::COLOUR_W-1:0]  in_pixel,
    output      logic                           adv,
    output      logic                           busy,
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    output      logic [lsfb_pkg::M_DATA_W-1:0]  m_tdata,
    output      logic                           m_tlast
);

    import lsfb_pkg::*;

    localparam int PROD_W = 2 * CHAN_W;

    // floor(p / 255), exact for every product of two 8-bit values
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] s;
        s = {1'b0, p} + (PROD_W + 1)'(p[PROD_W-1:CHAN_W]) + (PROD_W + 1)'(1);
        return s[PROD_W-1:CHAN_W];
    endfunction

    beat_t             prod_beat_reg;
    logic [PROD_W-1:0] prod_r_reg, prod_g_reg, prod_b_reg;
    logic              out_valid_reg;
    logic              out_last_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    assign adv  = !out_valid_reg || m_tready;
    assign busy = prod_beat_reg.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_beat_reg <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end else if (adv) begin
            prod_beat_reg <= in_beat;
            out_valid_reg <= prod_beat_reg.valid;
            out_last_reg  <= prod_beat_reg.last;
        end
        if (adv) begin
            prod_r_reg   <= in_pixel[3*CHAN_W-1:2*CHAN_W] * brightness;
            prod_g_reg   <= in_pixel[2*CHAN_W-1:CHAN_W] * brightness;
            prod_b_reg   <= in_pixel[CHAN_W-1:0] * brightness;
            out_data_reg <= {div255(prod_g_reg), div255(prod_r_reg), div255(prod_b_reg)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* hw/rtl/led_strip_frame_buffer_top.sv */
// Top level of the LED strip frame buffer: command sequencer, pixel RAM and show stream.
`default_nettype none

// Frame store for an addressable LED strip, one command per input item.
// Commands are handled one at a time. set_pixel writes its pixel as the
// item is taken; fill, clear and chase make one write per active LED after
// the item is taken. Rainbow first runs a serial divide for the hue spacing,
// then walks the active LEDs. When enabled, show streams one scaled GRB word
// per active LED at one word per cycle while the output is not stalled. The
// pixel RAM has a single write port and a single read port. The user must
// write configuration only while the block is idle; the block does not enforce it.

module led_strip_frame_buffer_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // pixel_index[6:0], red[14:7], green[22:15], blue[30:23], hue_offset[38:31]
    input  wire logic [lsfb_pkg::S_DATA_W-1:0]   s_tdata,
    // command[2:0]
    input  wire logic [lsfb_pkg::CMD_W-1:0]      s_tuser,
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // grb_word[23:0]
    output      logic [lsfb_pkg::M_DATA_W-1:0]   m_tdata,
    output      logic                            m_tlast,
    input  wire logic                            cfg_wr_en,
    input  wire logic [lsfb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lsfb_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    import lsfb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_SHOW = 2'd3;

    function automatic logic [COLOUR_W-1:0] hue_to_rgb(input logic [CHAN_W-1:0] hue);
        logic [2:0]        region;
        logic [CHAN_W-1:0] base;
        logic [CHAN_W-1:0] d;
        logic [CHAN_W-1:0] t;
        logic [CHAN_W-1:0] q;
        logic [COLOUR_W-1:0] rgb;
        if (hue >= CHAN_W'(5 * HUE_REGION)) begin
            region = 3'd5; base = CHAN_W'(5 * HUE_REGION);
        end else if (hue >= CHAN_W'(4 * HUE_REGION)) begin
            region = 3'd4; base = CHAN_W'(4 * HUE_REGION);
        end else if (hue >= CHAN_W'(3 * HUE_REGION)) begin
            region = 3'd3; base = CHAN_W'(3 * HUE_REGION);
        end else if (hue >= CHAN_W'(2 * HUE_REGION)) begin
            region = 3'd2; base = CHAN_W'(2 * HUE_REGION);
        end else if (hue >= CHAN_W'(HUE_REGION)) begin
            region = 3'd1; base = CHAN_W'(HUE_REGION);
        end else begin
            region = 3'd0; base = '0;
        end
        d = hue - base;
        t = {d[CHAN_W-3:0], 2'b00} + {d[CHAN_W-2:0], 1'b0};
        q = 8'hFF - t;
        case (region)
            3'd0:    rgb = {8'hFF, t, 8'h00};
            3'd1:    rgb = {q, 8'hFF, 8'h00};
            3'd2:    rgb = {8'h00, 8'hFF, t};
            3'd3:    rgb = {8'h00, q, 8'hFF};
            3'd4:    rgb = {t, 8'h00, 8'hFF};
            default: rgb = {8'hFF, 8'h00, q};
        endcase
        return rgb;
    endfunction

    // Input fields
    logic [PIX_IDX_W-1:0] in_idx;
    logic [COLOUR_W-1:0]  in_colour;
    logic [CHAN_W-1:0]    in_offset;

    assign in_idx    = s_tdata[6:0];
    assign in_colour = {s_tdata[14:7], s_tdata[22:15], s_tdata[30:23]};
    assign in_offset = s_tdata[38:31];

    // Configuration
    logic [LEDCOUNT_W-1:0] led_count_reg;
    logic [CHAN_W-1:0]     brightness_reg;
    logic                  enabled_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_count_reg  <= LEDCOUNT_W'(1);
            brightness_reg <= 8'hFF;
            enabled_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_LED_COUNT:  led_count_reg  <= cfg_wr_data[LEDCOUNT_W-1:0];
                CFG_BRIGHTNESS: brightness_reg <= cfg_wr_data[CHAN_W-1:0];
                CFG_ENABLED:    enabled_reg    <= cfg_wr_data[0];
                default:        ;
            endcase
        end
    end

    logic [CNT_W-1:0] n_act;

    always_comb begin
        if (led_count_reg == '0) begin
            n_act = CNT_W'(1);
        end else if (led_count_reg > LEDCOUNT_W'(MAX_LEDS)) begin
            n_act = CNT_W'(MAX_LEDS);
        end else begin
            n_act = CNT_W'(led_count_reg);
        end
    end

    // Sequencer state
    logic [1:0]           state_reg,  state_next;
    logic [CMD_W-1:0]     cmd_reg,    cmd_next;
    logic [PIX_IDX_W-1:0] idx_reg,    idx_next;
    logic [COLOUR_W-1:0]  colour_reg, colour_next;
    logic [CHAN_W-1:0]    offset_reg, offset_next;
    logic [CNT_W-1:0]     cnt_reg,    cnt_next;
    logic [CHAN_W-1:0]    hq_reg,     hq_next;
    logic [CNT_W-1:0]     hr_reg,     hr_next;
    logic [CHAN_W-1:0]    qstep_reg,  qstep_next;
    logic [CNT_W-1:0]     rstep_reg,  rstep_next;
    beat_t                rd_beat_reg, rd_beat_next;
    logic                 rd_vld_reg;
    logic [MAX_LEDS-1:0]  vld_reg,    vld_next;

    logic                 accept;
    logic                 div_start;
    logic                 div_done;
    logic [HUE_DIV_W-1:0] div_quot;
    logic [CNT_W-1:0]     div_rem;
    logic                 sc_adv;
    logic                 sc_busy;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [COLOUR_W-1:0]  ram_wdata;
    logic                 ram_re;
    logic [COLOUR_W-1:0]  ram_rdata;
    logic [COLOUR_W-1:0]  rd_pixel;
    logic                 last_step;
    logic [CNT_W:0]       hr_sum;
    logic [CHAN_W-1:0]    hue_now;

    assign s_tready  = (state_reg == ST_IDLE) && !rd_beat_reg.valid && !sc_busy;
    assign accept    = s_tvalid && s_tready;
    assign last_step = (cnt_reg == n_act - CNT_W'(1));
    assign hr_sum    = {1'b0, hr_reg} + {1'b0, rstep_reg};
    assign hue_now   = hq_reg + offset_reg;

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        idx_next     = idx_reg;
        colour_next  = colour_reg;
        offset_next  = offset_reg;
        cnt_next     = cnt_reg;
        hq_next      = hq_reg;
        hr_next      = hr_reg;
        qstep_next   = qstep_reg;
        rstep_next   = rstep_reg;
        rd_beat_next = rd_beat_reg;
        vld_next     = vld_reg;
        div_start    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = cnt_reg[IDX_W-1:0];
        ram_wdata    = '0;
        ram_re       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next    = s_tuser;
                    idx_next    = in_idx;
                    colour_next = in_colour;
                    offset_next = in_offset;
                    cnt_next    = '0;
                    case (s_tuser) inside
                        CMD_SET_PIXEL: begin
                            if ((CNT_W + PIX_IDX_W)'(in_idx) < (CNT_W + PIX_IDX_W)'(n_act)) begin
                                ram_we    = 1'b1;
                                ram_waddr = in_idx[IDX_W-1:0];
                                ram_wdata = in_colour;
                            end
                        end
                        CMD_FILL, CMD_CLEAR, CMD_CHASE: state_next = ST_WALK;
                        CMD_RAINBOW: begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                        CMD_SHOW: begin
                            if (enabled_reg) begin
                                state_next = ST_SHOW;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    qstep_next = div_quot[CHAN_W-1:0];
                    rstep_next = div_rem;
                    hq_next    = '0;
                    hr_next    = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                ram_we = 1'b1;
                case (cmd_reg)
                    CMD_FILL: ram_wdata = colour_reg;
                    CMD_CHASE: begin
                        if ((CNT_W + PIX_IDX_W)'(cnt_reg) == (CNT_W + PIX_IDX_W)'(idx_reg)) begin
                            ram_wdata = colour_reg;
                        end
                    end
                    CMD_RAINBOW: ram_wdata = hue_to_rgb(hue_now);
                    default: ram_wdata = '0;
                endcase
                // next hue position: quotient and remainder of i*256/count
                if (hr_sum >= {1'b0, n_act}) begin
                    hr_next = CNT_W'(hr_sum - {1'b0, n_act});
                    hq_next = hq_reg + qstep_reg + CHAN_W'(1);
                end else begin
                    hr_next = hr_sum[CNT_W-1:0];
                    hq_next = hq_reg + qstep_reg;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_step) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SHOW: begin
                if (sc_adv) begin
                    if (cnt_reg != n_act) begin
                        ram_re             = 1'b1;
                        rd_beat_next.valid = 1'b1;
                        rd_beat_next.last  = last_step;
                        cnt_next           = cnt_reg + CNT_W'(1);
                    end else begin
                        rd_beat_next = '0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (ram_we) begin
            vld_next[ram_waddr] = 1'b1;
        end
        if (sc_adv && state_reg != ST_SHOW) begin
            rd_beat_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            rd_beat_reg <= '0;
            vld_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_beat_reg <= rd_beat_next;
            vld_reg     <= vld_next;
        end
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        colour_reg <= colour_next;
        offset_reg <= offset_next;
        hq_reg     <= hq_next;
        hr_reg     <= hr_next;
        qstep_reg  <= qstep_next;
        rstep_reg  <= rstep_next;
        if (ram_re) begin
            rd_vld_reg <= vld_reg[cnt_reg[IDX_W-1:0]];
        end
    end

    // never-written entries read as zero
    assign rd_pixel = rd_vld_reg ? ram_rdata : '0;

    lsfb_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (MAX_LEDS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    lsfb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .divisor (n_act),
        .done    (div_done),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    lsfb_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .brightness (brightness_reg),
        .in_beat    (rd_beat_reg),
        .in_pixel   (rd_pixel),
        .adv        (sc_adv),
        .busy       (sc_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

/* hw/rtl/lsfb_checker.sv */
// Port-level checks on the frame buffer top, bound to every instance.
`default_nettype none

module lsfb_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [lsfb_pkg::CMD_W-1:0]    s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [lsfb_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                          m_tlast
);

    import lsfb_pkg::*;

    // stream out is empty straight after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // commands other than show start no stream
    a_no_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != CMD_SHOW |=> !$rose(m_tvalid))
        else $error("result produced by a non-show command");

    // no new command while a show is still mid-stream
    a_show_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("command taken during a show");

endmodule

bind led_strip_frame_buffer_top lsfb_checker u_lsfb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

/* tb/tb.sv */
// Testbench for the LED strip frame buffer: directed and random commands, with show output checked.
`timescale 1ns / 1ps

module tb;

    import lsfb_pkg::*;

    localparam int  HALF_PERIOD = 2;
    localparam int  RESET_CYCLES = 8;
    localparam int  SETTLE_CYCLES = 200;
    localparam int  HOLD_CYCLES = 600;
    localparam int  CYCLE_LIMIT = 3_000_000;
    localparam int  MAX_REPORTS = 10;
    localparam int  RANDOM_PHASES = 8;
    localparam int  ITEMS_PER_PHASE = 25;

    // codes with no command behind them
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    typedef struct {
        logic [23:0] grb;
        logic        last;
    } strip_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic m_tlast;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    // predicted strip state, stored red 23:16, green 15:8, blue 7:0
    logic [23:0] strip_rgb [MAX_LEDS];
    logic [6:0]  strip_count;
    logic [7:0]  strip_level;
    logic        strip_on;

    strip_word_t shown_words[$];
    int          n_mismatch = 0;
    int          cycle_cnt = 0;
    bit          tx_idle_on = 1'b0;
    bit          rx_idle_on = 1'b0;
    int          hold_reqs = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          rx_gap = 0;

    led_strip_frame_buffer_top u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom_range(1, 3);
        else if (r < 19)
            return $urandom_range(4, 8);
        return $urandom_range(20, 40);
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_reqs != hold_seen) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_reqs;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end else begin
            m_tready <= 1'b1;
            if (rx_idle_on && $urandom_range(0, 3) == 0)
                rx_gap <= pick_gap();
        end
    end

    task automatic note_mismatch(input string msg);
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin : check_words
        strip_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (shown_words.size() == 0) begin
                note_mismatch($sformatf("unexpected item grb=%06h last=%0b", m_tdata, m_tlast));
            end else begin
                want = shown_words.pop_front();
                if (m_tdata !== want.grb || m_tlast !== want.last)
                    note_mismatch($sformatf("grb exp %06h got %06h, last exp %0b got %0b",
                                            want.grb, m_tdata, want.last, m_tlast));
            end
        end
    end

    function automatic int live_leds();
        if (strip_count == 0)
            return 1;
        if (strip_count > MAX_LEDS)
            return MAX_LEDS;
        return int'(strip_count);
    endfunction

    function automatic logic [23:0] wheel_rgb(input int hue);
        int region;
        int t;
        int q;
        region = hue / 43;
        t = (hue - 43 * region) * 6;
        q = 255 - t;
        case (region)
            0: return {8'd255, t[7:0], 8'd0};
            1: return {q[7:0], 8'd255, 8'd0};
            2: return {8'd0, 8'd255, t[7:0]};
            3: return {8'd0, q[7:0], 8'd255};
            4: return {t[7:0], 8'd0, 8'd255};
            default: return {8'd255, 8'd0, q[7:0]};
        endcase
    endfunction

    function automatic logic [7:0] dim(input logic [7:0] c);
        int v;
        v = (int'(c) * int'(strip_level)) / 255;
        return v[7:0];
    endfunction

    // updates the strip state for one accepted command and queues any show output
    task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [6:0] idx,
                                 input logic [23:0] rgb, input logic [7:0] offset);
        int n;
        int hue;
        strip_word_t w;
        n = live_leds();
        case (cmd)
            CMD_SET_PIXEL: begin
                if (idx < n)
                    strip_rgb[idx[5:0]] = rgb;
            end
            CMD_FILL: begin
                for (int i = 0; i < n; i++)
                    strip_rgb[i] = rgb;
            end
            CMD_CLEAR: begin
                for (int i = 0; i < n; i++)
                    strip_rgb[i] = '0;
            end
            CMD_CHASE: begin
                for (int i = 0; i < n; i++)
                    strip_rgb[i] = '0;
                if (idx < n)
                    strip_rgb[idx[5:0]] = rgb;
            end
            CMD_RAINBOW: begin
                for (int i = 0; i < n; i++) begin
                    hue = ((i * 256) / n + offset) & 8'hFF;
                    strip_rgb[i] = wheel_rgb(hue);
                end
            end
            CMD_SHOW: begin
                if (strip_on) begin
                    for (int i = 0; i < n; i++) begin
                        w.grb = {dim(strip_rgb[i][15:8]), dim(strip_rgb[i][23:16]),
                                 dim(strip_rgb[i][7:0])};
                        w.last = (i == n - 1);
                        shown_words.push_back(w);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // called at a rising edge; returns at the edge where the item was taken
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [6:0] idx,
                             input logic [23:0] rgb, input logic [7:0] offset);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 1) == 0)
            gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {1'b0, offset, rgb[7:0], rgb[15:8], rgb[23:16], idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_command(cmd, idx, rgb, offset);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (shown_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        case (idx)
            CFG_LED_COUNT:  strip_count = value[6:0];
            CFG_BRIGHTNESS: strip_level = value;
            CFG_ENABLED:    strip_on = value[0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_reset_state();
        cfg_write(CFG_ENABLED, 8'd1);
        send_item(CMD_SHOW, '0, '0, '0);
        wait_idle();
    endtask

    task automatic test_each_command();
        cfg_write(CFG_LED_COUNT, 8'd8);
        send_item(CMD_SET_PIXEL, 7'd0, 24'hFFFFFF, 8'h00);
        send_item(CMD_SET_PIXEL, 7'd7, 24'h00FF00, 8'hFF);
        send_item(CMD_SET_PIXEL, 7'd5, 24'hFF00FF, 8'h00);
        send_item(CMD_SET_PIXEL, 7'd8, 24'h123456, 8'h00);
        send_item(CMD_SET_PIXEL, 7'd127, 24'hABCDEF, 8'h00);
        send_item(CMD_SHOW, 7'd127, 24'hFFFFFF, 8'hFF);
        send_item(CMD_FILL, 7'd0, 24'h123456, 8'h00);
        send_item(CMD_SHOW, '0, '0, '0);
        send_item(CMD_CHASE, 7'd3, 24'h80FF01, 8'h00);
        send_item(CMD_SHOW, '0, '0, '0);
        // position beyond the count: clears, lights nothing
        send_item(CMD_CHASE, 7'd100, 24'hFFFFFF, 8'h00);
        send_item(CMD_SHOW, '0, '0, '0);
        send_item(CMD_RAINBOW, '0, '0, 8'h00);
        send_item(CMD_SHOW, '0, '0, '0);
        send_item(CMD_RAINBOW, '0, '0, 8'hFF);
        send_item(CMD_SHOW, '0, '0, '0);
        send_item(CMD_CLEAR, 7'd55, 24'hFFFFFF, 8'hFF);
        send_item(CMD_SPARE_A, 7'd1, 24'hFFFFFF, 8'hFF);
        send_item(CMD_SPARE_B, 7'd2, 24'hFFFFFF, 8'hFF);
        send_item(CMD_SHOW, '0, '0, '0);
        wait_idle();
    endtask

    task automatic test_count_limits();
        cfg_write(CFG_LED_COUNT, 8'd0);
        send_item(CMD_RAINBOW, '0, '0, 8'h80);
        send_item(CMD_SHOW, '0, '0, '0);
        wait_idle();
        cfg_write(CFG_LED_COUNT, 8'd127);
        send_item(CMD_FILL, '0, 24'hAA55C3, 8'h00);
        wait_idle();
        // shrink, clear the head, then show the full strip again
        cfg_write(CFG_LED_COUNT, 8'd4);
        send_item(CMD_CLEAR, '0, '0, '0);
        wait_idle();
        cfg_write(CFG_LED_COUNT, 8'd64);
        cfg_write(CFG_BRIGHTNESS, 8'd0);
        send_item(CMD_SHOW, '0, '0, '0);
        wait_idle();
        cfg_write(CFG_BRIGHTNESS, 8'd1);
        send_item(CMD_RAINBOW, '0, '0, 8'h2B);
        send_item(CMD_SHOW, '0, '0, '0);
        wait_idle();
        cfg_write(CFG_ENABLED, 8'd0);
        send_item(CMD_SHOW, '0, '0, '0);
        wait_idle();
        cfg_write(CFG_ENABLED, 8'd1);
        cfg_write(CFG_BRIGHTNESS, 8'd255);
    endtask

    task automatic test_backpressure();
        wait_idle();
        cfg_write(CFG_LED_COUNT, 8'd64);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_item(CMD_RAINBOW, '0, '0, 8'h11);
        hold_reqs++;
        for (int k = 0; k < 6; k++)
            send_item(CMD_SHOW, '0, '0, '0);
        wait_idle();
    endtask

    task automatic set_random_config();
        int r;
        logic [7:0] v;
        r = $urandom_range(0, 9);
        if (r < 6)
            v = 8'($urandom_range(1, 8));
        else if (r < 8)
            v = 8'($urandom_range(9, 20));
        else if (r == 8)
            v = 8'd64;
        else
            case ($urandom_range(0, 3))
                0: v = 8'd0;
                1: v = 8'd127;
                2: v = 8'd65;
                default: v = 8'h83;
            endcase
        cfg_write(CFG_LED_COUNT, v);
        r = $urandom_range(0, 3);
        v = (r == 0) ? 8'd255 : (r == 1) ? 8'd0 : 8'($urandom_range(0, 255));
        cfg_write(CFG_BRIGHTNESS, v);
        cfg_write(CFG_ENABLED, ($urandom_range(0, 5) == 0) ? 8'd0 : 8'd1);
    endtask

    task automatic test_random_traffic();
        int counted;
        int r;
        int n;
        logic [CMD_W-1:0] cmd;
        logic [6:0] idx;
        logic [23:0] rgb;
        logic [7:0] offset;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_random_config();
            tx_idle_on = (ph % 3 != 2);
            rx_idle_on = (ph % 4 != 3);
            n = live_leds();
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                r = $urandom_range(0, 99);
                rgb = 24'($urandom());
                offset = 8'($urandom_range(0, 255));
                idx = ($urandom_range(0, 6) == 0) ? 7'($urandom_range(n, 127))
                                                  : 7'($urandom_range(0, n - 1));
                if (r < 30)
                    cmd = CMD_SET_PIXEL;
                else if (r < 42)
                    cmd = CMD_FILL;
                else if (r < 50)
                    cmd = CMD_CLEAR;
                else if (r < 60)
                    cmd = CMD_CHASE;
                else if (r < 70)
                    cmd = CMD_RAINBOW;
                else if (r < 95)
                    cmd = CMD_SHOW;
                else
                    cmd = r[0] ? CMD_SPARE_A : CMD_SPARE_B;
                send_item(cmd, idx, rgb, offset);
                if (!(cmd == CMD_SPARE_A || cmd == CMD_SPARE_B ||
                      (cmd == CMD_SET_PIXEL && idx >= n)))
                    counted++;
            end
            wait_idle();
        end
    endtask

    initial begin
        for (int i = 0; i < MAX_LEDS; i++)
            strip_rgb[i] = '0;
        strip_count = 7'd1;
        strip_level = 8'd255;
        strip_on = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_each_command();
        test_count_limits();
        test_backpressure();
        test_random_traffic();

        if (n_mismatch == 0 && shown_words.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
